/* hdl/mie_pkg.sv */
// shared types and constants of the modular inverse block
package mie_pkg;

    localparam int FIELD_W   = 32;
    localparam int WIDTH_DEF = 32;

    typedef struct packed {
        logic load;
        logic start_div;
        logic shift_up;
        logic div_step;
        logic commit;
        logic reduce;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic r1_zero;
        logic can_shift;
        logic at_divisor;
    } sts_t;

endpackage

/* hdl/mie_datapath.sv */
// remainder / coefficient datapath with a shift-subtract divider
module mie_datapath import mie_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic               aclk,
    input  logic [FIELD_W-1:0] s_value,
    input  logic [FIELD_W-1:0] s_modulus,
    input  logic               aresetn,
    input  cmd_t               cmd_i,
    output sts_t               sts_o,
    output logic               m_exists,
    output logic [FIELD_W-1:0] m_inverse
);

    localparam int UW = WIDTH + 1;

    logic [WIDTH-1:0] m_reg, m_next;
    logic [WIDTH-1:0] r0_reg, r0_next;
    logic [WIDTH-1:0] r1_reg, r1_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [UW-1:0]    u0_reg, u0_next;
    logic [UW-1:0]    u1_reg, u1_next;
    logic [UW-1:0]    ud_reg, ud_next;
    logic [UW-1:0]    acc_reg, acc_next;
    logic             odd_reg, odd_next;
    logic             exists_reg, exists_next;
    logic [FIELD_W-1:0] inverse_reg, inverse_next;

    logic [UW-1:0]    d_dbl;
    logic [UW-1:0]    diff;
    logic             ge;
    logic [UW-1:0]    m_ext;
    logic             exists_c;
    logic [UW-1:0]    inv_full;

    assign d_dbl    = {d_reg, 1'b0};
    assign diff     = {1'b0, rem_reg} - {1'b0, d_reg};
    assign ge       = !diff[WIDTH];
    assign m_ext    = {1'b0, m_reg};
    assign exists_c = (r0_reg == WIDTH'(1)) && (m_reg != '0);

    // odd step count: coefficient is already the inverse, else negate mod m
    always_comb begin
        if (!exists_c) begin
            inv_full = '0;
        end else if (odd_reg || u0_reg == '0) begin
            inv_full = u0_reg;
        end else begin
            inv_full = m_ext - u0_reg;
        end
    end

    assign sts_o.r1_zero    = (r1_reg == '0);
    assign sts_o.can_shift  = (d_dbl <= {1'b0, rem_reg});
    assign sts_o.at_divisor = (d_reg == r1_reg);

    always_comb begin
        m_next       = m_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        u0_next      = u0_reg;
        u1_next      = u1_reg;
        ud_next      = ud_reg;
        acc_next     = acc_reg;
        odd_next     = odd_reg;
        exists_next  = exists_reg;
        inverse_next = inverse_reg;
        if (cmd_i.load) begin
            m_next   = WIDTH'(s_modulus);
            r0_next  = WIDTH'(s_modulus);
            r1_next  = WIDTH'(s_value);
            u0_next  = '0;
            u1_next  = UW'(1);
            odd_next = 1'b0;
        end
        if (cmd_i.start_div) begin
            rem_next = r0_reg;
            d_next   = r1_reg;
            ud_next  = u1_reg;
            acc_next = u0_reg;
        end
        if (cmd_i.shift_up) begin
            d_next  = d_dbl[WIDTH-1:0];
            ud_next = {ud_reg[UW-2:0], 1'b0};
        end
        if (cmd_i.div_step) begin
            if (ge) begin
                rem_next = diff[WIDTH-1:0];
                acc_next = acc_reg + ud_reg;
            end
            if (d_reg != r1_reg) begin
                d_next  = d_reg >> 1;
                ud_next = ud_reg >> 1;
            end
        end
        if (cmd_i.commit) begin
            r0_next  = r1_reg;
            r1_next  = rem_reg;
            u0_next  = u1_reg;
            u1_next  = acc_reg;
            odd_next = !odd_reg;
        end
        if (cmd_i.reduce) begin
            if (u0_reg >= m_ext) begin
                u0_next = u0_reg - m_ext;
            end
        end
        if (cmd_i.emit) begin
            exists_next  = exists_c;
            inverse_next = FIELD_W'(inv_full);
        end
    end

    always_ff @(posedge aclk) begin
        m_reg       <= m_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        u0_reg      <= u0_next;
        u1_reg      <= u1_next;
        ud_reg      <= ud_next;
        acc_reg     <= acc_next;
        odd_reg     <= odd_next;
        exists_reg  <= exists_next;
        inverse_reg <= inverse_next;
    end

    assign m_exists  = exists_reg;
    assign m_inverse = inverse_reg;

    a_rem_below_divisor : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.commit |-> rem_reg < r1_reg)
        else $error("remainder not below divisor at step end");

    a_coef_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.commit |-> acc_reg <= m_ext)
        else $error("bezout coefficient exceeds modulus");

    a_inverse_in_range : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_i.emit && exists_c |-> inv_full < m_ext)
        else $error("inverse not reduced below modulus");

endmodule

/* hdl/mie_ctrl.sv */
// sequencer for the euclid steps and the result handshake
module mie_ctrl import mie_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  sts_t sts_i,
    output cmd_t cmd_o
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CHECK  = 7'b0000010,
        S_ALIGN  = 7'b0000100,
        S_DIVIDE = 7'b0001000,
        S_COMMIT = 7'b0010000,
        S_REDUCE = 7'b0100000,
        S_EMIT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    always_comb begin
        state_next = state_reg;
        cmd_o      = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_o.load = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts_i.r1_zero) begin
                    state_next = S_REDUCE;
                end else begin
                    cmd_o.start_div = 1'b1;
                    state_next      = S_ALIGN;
                end
            end
            S_ALIGN: begin
                if (sts_i.can_shift) begin
                    cmd_o.shift_up = 1'b1;
                end else begin
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE: begin
                cmd_o.div_step = 1'b1;
                if (sts_i.at_divisor) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd_o.commit = 1'b1;
                state_next   = S_CHECK;
            end
            S_REDUCE: begin
                cmd_o.reduce = 1'b1;
                state_next   = S_EMIT;
            end
            S_EMIT: begin
                // result register free or being drained this cycle
                if (!m_valid_reg || m_ready) begin
                    cmd_o.emit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd_o.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    a_emit_slot_free : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_o.emit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before transfer");

    a_accept_starts : assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_CHECK && !s_ready)
        else $error("accepted item did not start");

    a_divide_ends : assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIVIDE && sts_i.at_divisor |=> state_reg == S_COMMIT)
        else $error("division did not end at the divisor");

endmodule

/* hdl/modular_inverse_ext_euclid.sv */
// Modular inverse by the extended Euclidean algorithm. One item at a time:
// s_ready is high only while the block is idle, and the result waits in an
// output register so the next item can be taken while it is pending. Each
// Euclid step divides by shift and subtract on one shared subtractor, through
// the states check, align, divide and commit; load comes before the steps,
// and reduction and result emission after them. exists is high when the gcd of
// value and modulus is one; inverse is then in 0..modulus-1, else zero.
// A zero modulus gives exists low. Operands are taken at WIDTH bits.
module modular_inverse_ext_euclid import mie_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_value,
    input  logic [FIELD_W-1:0] s_modulus,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_exists,
    output logic [FIELD_W-1:0] m_inverse
);

    cmd_t cmd;
    sts_t sts;

    mie_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts_i   (sts),
        .cmd_o   (cmd)
    );

    mie_datapath #(
        .WIDTH (WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .s_value   (s_value),
        .s_modulus (s_modulus),
        .aresetn   (aresetn),
        .cmd_i     (cmd),
        .sts_o     (sts),
        .m_exists  (m_exists),
        .m_inverse (m_inverse)
    );

endmodule

/* dv/modular_inverse_ext_euclid_checker.sv */
// checker for the modular inverse block: predicts each result and compares it on transfer
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_checker import mie_pkg::*; #(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [FIELD_W-1:0] s_value,
    input  logic [FIELD_W-1:0] s_modulus,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_exists,
    input  logic [FIELD_W-1:0] m_inverse,
    output int                 errors,
    output int                 pending,
    output int                 n_results,
    output int                 n_invertible
);

    typedef struct packed {
        logic               exists;
        logic [FIELD_W-1:0] inverse;
    } inv_result_t;

    inv_result_t inverse_due[$];

    function automatic inv_result_t calc_inverse(logic [FIELD_W-1:0] value,
                                                 logic [FIELD_W-1:0] modulus);
        logic [63:0] op_mask;
        logic [63:0] v, m, rem_a, rem_b, rem_n, co_a, co_b, co_n, quo;
        int unsigned n_steps;
        inv_result_t res;
        op_mask = (WIDTH >= 64) ? '1 : ((64'd1 << WIDTH) - 64'd1);
        v = 64'(value) & op_mask;
        m = 64'(modulus) & op_mask;
        res = '0;
        if (m == 0)
            return res;
        rem_a = m;
        rem_b = v % m;
        co_a = 0;
        co_b = 1;
        n_steps = 0;
        // coefficients kept as magnitudes, sign alternates per step
        while (rem_b != 0) begin
            quo   = rem_a / rem_b;
            rem_n = rem_a - quo * rem_b;
            co_n  = co_a + quo * co_b;
            rem_a = rem_b;
            rem_b = rem_n;
            co_a  = co_b;
            co_b  = co_n;
            n_steps++;
        end
        if (rem_a != 1)
            return res;
        co_a = co_a % m;
        res.exists = 1'b1;
        if (!n_steps[0] && co_a != 0)
            res.inverse = FIELD_W'(m - co_a);
        else
            res.inverse = FIELD_W'(co_a);
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        inv_result_t want;
        if (aresetn) begin
            // retire before queueing so a spurious result never matches a fresh item
            if (m_valid && m_ready) begin
                n_results++;
                if (m_exists)
                    n_invertible++;
                if (inverse_due.size() == 0) begin
                    $display("%0t: unexpected result transfer, actual exists %0b inverse %0h",
                             $time, m_exists, m_inverse);
                    errors++;
                end else begin
                    want = inverse_due.pop_front();
                    if (m_exists !== want.exists) begin
                        $display("%0t: exists mismatch, expected %0b, actual %0b",
                                 $time, want.exists, m_exists);
                        errors++;
                    end
                    if (m_inverse !== want.inverse) begin
                        $display("%0t: inverse mismatch, expected %0h, actual %0h",
                                 $time, want.inverse, m_inverse);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready)
                inverse_due.push_back(calc_inverse(s_value, s_modulus));
            pending <= inverse_due.size();
        end
    end

endmodule

/* dv/modular_inverse_ext_euclid_tb.sv */
// testbench top for the modular inverse block: stimulus, flow control and verdict
`timescale 1ns / 100ps

module modular_inverse_ext_euclid_tb import mie_pkg::*;;

    localparam int RAND_ITEMS = 1530;
    localparam int TAIL_ITEMS = 150;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [FIELD_W-1:0] s_value;
    logic [FIELD_W-1:0] s_modulus;
    logic               m_valid;
    logic               m_ready;
    logic               m_exists;
    logic [FIELD_W-1:0] m_inverse;

    int errors, pending, n_results, n_invertible;
    int sent;
    bit quiet;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    modular_inverse_ext_euclid dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_value   (s_value),
        .s_modulus (s_modulus),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_exists  (m_exists),
        .m_inverse (m_inverse)
    );

    modular_inverse_ext_euclid_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value      (s_value),
        .s_modulus    (s_modulus),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_exists     (m_exists),
        .m_inverse    (m_inverse),
        .errors       (errors),
        .pending      (pending),
        .n_results    (n_results),
        .n_invertible (n_invertible)
    );

    task automatic send_item(input logic [FIELD_W-1:0] v, input logic [FIELD_W-1:0] m);
        s_valid   <= 1'b1;
        s_value   <= v;
        s_modulus <= m;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent++;
    endtask

    task automatic pause_sender(input int n);
        s_valid <= 1'b0;
        repeat (n) @(posedge aclk);
    endtask

    // hold off until every queued result has come back
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
    endtask

    task automatic pick_operands(output logic [FIELD_W-1:0] v, output logic [FIELD_W-1:0] m);
        int unsigned kind, f;
        logic [FIELD_W-1:0] v_mask, m_mask;
        kind   = $urandom_range(0, 15);
        v_mask = {FIELD_W{1'b1}} >> $urandom_range(0, FIELD_W - 1);
        m_mask = {FIELD_W{1'b1}} >> $urandom_range(0, FIELD_W - 1);
        v = $urandom;
        m = $urandom;
        case (kind) inside
            0: m = '0;
            1: m = $urandom_range(1, 16);
            [2:4]: begin
                m = m & m_mask;
                v = v & v_mask;
                if (m == 0)
                    m = 1;
            end
            5: begin
                m = m & m_mask | 1;
                v = m - 1;
            end
            6: begin
                // shared factor, so no inverse
                f = $urandom_range(2, 1000);
                m = f * $urandom_range(1, 4000000);
                v = f * $urandom_range(0, 4000000);
            end
            default: ;
        endcase
    endtask

    initial begin : result_sink
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    initial begin : stimulus
        logic [FIELD_W-1:0] v, m;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_value   <= '0;
        s_modulus <= '0;
        quiet     <= 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // modulus one, zero value, values at or above the modulus, extremes
        send_item(32'd0, 32'd1);
        send_item(32'hFFFFFFFF, 32'd1);
        send_item(32'd0, 32'd7);
        send_item(32'd0, 32'hFFFFFFFF);
        send_item(32'd3, 32'd7);
        send_item(32'd10, 32'd7);
        send_item(32'd7, 32'd7);
        send_item(32'd6, 32'd9);
        send_item(32'd1, 32'd2);
        send_item(32'd1, 32'hFFFFFFFF);
        send_item(32'hFFFFFFFE, 32'hFFFFFFFF);
        send_item(32'hFFFFFFFF, 32'hFFFFFFFF);
        send_item(32'hFFFFFFFF, 32'hFFFFFFFE);
        send_item(32'd3, 32'h80000000);
        send_item(32'd2, 32'h80000000);
        // consecutive fibonacci numbers give the longest recurrence
        send_item(32'd1836311903, 32'd2971215073);
        send_item(32'd2971215073, 32'd1836311903);
        // zero modulus, outside the nominal range
        send_item(32'd0, 32'd0);
        send_item(32'd5, 32'd0);
        send_item(32'hFFFFFFFF, 32'd0);
        drain_results();

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i == RAND_ITEMS - TAIL_ITEMS)
                quiet <= 1'b1;
            if (i == RAND_ITEMS / 2)
                drain_results();
            if (!quiet && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 12));
            pick_operands(v, m);
            send_item(v, m);
        end
        drain_results();
        repeat (300) @(posedge aclk);

        $display("sent %0d operand pairs incl. zero and unit moduli", sent);
        $display("%0d results checked, %0d invertible", n_results, n_invertible);
        if (errors == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin : watchdog
        #50000000;
        $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
hdl/mie_pkg.sv
hdl/mie_datapath.sv
hdl/mie_ctrl.sv
hdl/modular_inverse_ext_euclid.sv
dv/modular_inverse_ext_euclid_checker.sv
dv/modular_inverse_ext_euclid_tb.sv
